[sv/ucfr_pkg.sv]
// Shared types and constants for the command frame receiver.
package ucfr_pkg;

	localparam int unsigned APB_ADDR_W         = 3;
	localparam int unsigned APB_DATA_W         = 32;
	localparam int unsigned BYTE_W             = 8;
	localparam int unsigned COUNT_W            = 9;
	localparam int unsigned CAPTURED_BYTES_DEF = 7;
	localparam int unsigned FRAME_OVERHEAD     = 2;   // type byte plus trailer

	localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;
	localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h55;

	// payload byte 0 flag positions
	localparam int unsigned TRIP_BIT = 0;
	localparam int unsigned TIME_BIT = 1;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_HEAD = 1'b0,
		REG_TAIL = 1'b1
	} reg_idx_t;

	typedef enum logic {
		STATUS_GOOD = 1'b0,
		STATUS_BAD  = 1'b1
	} frame_status_t;

	typedef struct packed {
		logic              frame_status;
		logic [BYTE_W-1:0] cmd_type;
		logic [BYTE_W-1:0] payload_length;
		logic              trip_clear;
		logic              time_set_en;
		logic [BYTE_W-1:0] menu_number;
		logic [BYTE_W-1:0] battery_box_number;
		logic [31:0]       utc_time;
	} result_t;

endpackage

[sv/uart_command_frame_receiver.sv]
// Command frame receiver: head/length/type/payload/tail framing over a byte stream.
//
// Usage:
//  - Input channel (in_valid / in_stall / rx_byte) carries one received serial
//    byte per request. A request is taken at a clock edge with in_valid high
//    and in_stall low; one byte can be taken every cycle.
//  - The byte is decoded in the cycle it is taken; the frame state updates at
//    that edge. The final byte of a frame yields one result, which is registered
//    into the output register (out_valid / out_stall), or into the skid register
//    first while the output is stalled. All other bytes yield nothing.
//  - Throughput is one byte per cycle while in_stall is low. The output
//    register is backed by a one-entry skid register, so a byte is still
//    taken while a result waits. in_stall rises only when both output register
//    and skid register hold results, i.e. after the downstream side has stalled.
//  - Configuration (APB, pready tied high): head byte at 0x0, tail byte at 0x4.
//    Write only while idle.
//  - Reset (arst_n low): back to hunting for the head byte, decoded fields
//    cleared, head 0xAA, tail 0x55, output and skid empty.
module uart_command_frame_receiver #(
	parameter int unsigned CAPTURED_BYTES = ucfr_pkg::CAPTURED_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ucfr_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ucfr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ucfr_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// byte input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ucfr_pkg::BYTE_W-1:0]         rx_byte,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                frame_status,
	output logic [ucfr_pkg::BYTE_W-1:0]         cmd_type,
	output logic [ucfr_pkg::BYTE_W-1:0]         payload_length,
	output logic                                trip_clear,
	output logic                                time_set_en,
	output logic [ucfr_pkg::BYTE_W-1:0]         menu_number,
	output logic [ucfr_pkg::BYTE_W-1:0]         battery_box_number,
	output logic [31:0]                         utc_time
);
	import ucfr_pkg::*;

	localparam logic [COUNT_W-1:0] OVERHEAD  = COUNT_W'(FRAME_OVERHEAD);
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'((1 << BYTE_W) - 1 + FRAME_OVERHEAD);

	// ---------------- configuration registers ----------------
	logic [BYTE_W-1:0] head_q;
	logic [BYTE_W-1:0] tail_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RESET;
			tail_q <= TAIL_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_HEAD: head_q <= pwdata[BYTE_W-1:0];
				REG_TAIL: tail_q <= pwdata[BYTE_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_HEAD: prdata = APB_DATA_W'(head_q);
			REG_TAIL: prdata = APB_DATA_W'(tail_q);
			default:  prdata = '0;
		endcase
	end

	// ---------------- frame state ----------------
	logic               hunting_q;
	logic               len_known_q;
	logic [BYTE_W-1:0]  frame_len_q;
	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0]  pend_type_q;
	logic [BYTE_W-1:0]  pend_pl_q [CAPTURED_BYTES];
	logic [BYTE_W-1:0]  cap_pl_q  [CAPTURED_BYTES];
	logic [BYTE_W-1:0]  dec_type_q;

	logic               hunting_d;
	logic               len_known_d;
	logic [BYTE_W-1:0]  frame_len_d;
	logic [COUNT_W-1:0] count_d;
	logic [BYTE_W-1:0]  pend_type_d;
	logic [BYTE_W-1:0]  pend_pl_d [CAPTURED_BYTES];
	logic [BYTE_W-1:0]  cap_pl_d  [CAPTURED_BYTES];
	logic [BYTE_W-1:0]  dec_type_d;

	logic               in_acc;
	logic               res_vld;
	logic               res_bad;
	logic [COUNT_W-1:0] pos_next;
	logic [COUNT_W-1:0] len_ext;
	result_t            res;

	assign in_acc   = in_valid && !in_stall;
	assign len_ext  = COUNT_W'(frame_len_q);
	assign pos_next = count_q + COUNT_W'(1);

	always_comb begin
		hunting_d   = hunting_q;
		len_known_d = len_known_q;
		frame_len_d = frame_len_q;
		count_d     = count_q;
		pend_type_d = pend_type_q;
		pend_pl_d   = pend_pl_q;
		cap_pl_d    = cap_pl_q;
		dec_type_d  = dec_type_q;
		res_vld     = 1'b0;
		res_bad     = 1'b0;

		if (in_acc) begin
			if (hunting_q) begin
				if (rx_byte == head_q) begin
					hunting_d   = 1'b0;
					len_known_d = 1'b0;
				end
			end else if (!len_known_q) begin
				frame_len_d = rx_byte;
				len_known_d = 1'b1;
				count_d     = '0;
			end else begin
				count_d = pos_next;
				if (count_q == '0) begin
					pend_type_d = rx_byte;
				end
				for (int i = 0; i < CAPTURED_BYTES; i++) begin
					if (count_q == COUNT_W'(i + 1) && count_q <= len_ext)
						pend_pl_d[i] = rx_byte;
				end
				// trailer: the last byte never lands in the pending buffer
				if (pos_next == len_ext + OVERHEAD) begin
					res_vld = 1'b1;
					res_bad = (rx_byte != tail_q);
					if (!res_bad) begin
						dec_type_d = pend_type_q;
						for (int i = 0; i < CAPTURED_BYTES; i++) begin
							if (COUNT_W'(i) < len_ext)
								cap_pl_d[i] = pend_pl_q[i];
						end
					end
					hunting_d   = 1'b1;
					len_known_d = 1'b0;
					count_d     = '0;
				end
			end
		end
	end

	always_comb begin
		res.frame_status       = res_bad ? STATUS_BAD : STATUS_GOOD;
		res.cmd_type           = dec_type_d;
		res.payload_length     = frame_len_q;
		res.trip_clear         = cap_pl_d[0][TRIP_BIT];
		res.time_set_en        = cap_pl_d[0][TIME_BIT];
		res.menu_number        = cap_pl_d[1];
		res.battery_box_number = cap_pl_d[2];
		res.utc_time           = {cap_pl_d[6], cap_pl_d[5], cap_pl_d[4], cap_pl_d[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q   <= 1'b1;
			len_known_q <= 1'b0;
			frame_len_q <= '0;
			count_q     <= '0;
			pend_type_q <= '0;
			dec_type_q  <= '0;
			for (int i = 0; i < CAPTURED_BYTES; i++)
				cap_pl_q[i] <= '0;
		end else begin
			hunting_q   <= hunting_d;
			len_known_q <= len_known_d;
			frame_len_q <= frame_len_d;
			count_q     <= count_d;
			pend_type_q <= pend_type_d;
			dec_type_q  <= dec_type_d;
			cap_pl_q    <= cap_pl_d;
		end
	end

	// pending bytes are always written before they are committed
	always_ff @(posedge clk) begin
		pend_pl_q <= pend_pl_d;
	end

	// ---------------- output register with skid ----------------
	logic    out_vld_q;
	logic    skid_vld_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign out_free = !out_vld_q || !out_stall;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res_vld;
			end
		end else if (res_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (res_vld) begin
			skid_q <= res;
		end
	end

	assign out_valid          = out_vld_q;
	assign frame_status       = out_q.frame_status;
	assign cmd_type           = out_q.cmd_type;
	assign payload_length     = out_q.payload_length;
	assign trip_clear         = out_q.trip_clear;
	assign time_set_en        = out_q.time_set_en;
	assign menu_number        = out_q.menu_number;
	assign battery_box_number = out_q.battery_box_number;
	assign utc_time           = out_q.utc_time;

`ifndef NO_ASSERTIONS
	// skid only fills behind a stalled, full output register
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a result while output register is empty");

	// after a finished frame the output register always holds a valid result next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |=> out_vld_q)
		else $error("completed frame produced no output");

	// length is only known once the head has been seen
	a_len_not_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		len_known_q |-> !hunting_q)
		else $error("length known while hunting");

	// byte counter never passes the longest frame
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("byte counter overran longest frame");

	// a stalled skid entry is not overwritten
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && out_stall) |=> (skid_vld_q && $stable(skid_q)))
		else $error("skid entry lost while output stalled");
`endif

endmodule
